// ----- src/albf_pkg.sv -----
package albf_pkg;

    // window geometry
    localparam int WINDOW_LEN = 5;
    localparam int SAMPLE_W   = 12;
    localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int COUNT_W    = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = $clog2((2 ** SAMPLE_W - 1) * WINDOW_LEN + 1);
    localparam int AVG_NUM_W  = SUM_W + 1;
    localparam int AVG_DEN_W  = COUNT_W + 1;

    // field widths
    localparam int ADC_HIGH_W = 13;
    localparam int BRIGHT_W   = 8;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int LEVEL_W    = BRIGHT_W + FRAC_W;
    localparam int DIFF_W     = LEVEL_W + 1;
    localparam int ACC_W      = GAIN_W + LEVEL_W;
    localparam int TOP_CNT_W  = $clog2((GAIN_W > SAMPLE_W) ? GAIN_W : SAMPLE_W);

    // curve unit widths
    localparam int SQ_W        = 2 * ADC_HIGH_W;
    localparam int PROD_W      = SQ_W + BRIGHT_W + 1;
    localparam int DIV_W       = SQ_W + 1;
    localparam int CURVE_CNT_W = $clog2(ADC_HIGH_W);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ADC_LOW        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADC_HIGH       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS_MIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS_MAX = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING_GAIN = 3'd4;

    localparam logic [SAMPLE_W-1:0]   RST_ADC_LOW        = 12'd100;
    localparam logic [ADC_HIGH_W-1:0] RST_ADC_HIGH       = 13'd1024;
    localparam logic [BRIGHT_W-1:0]   RST_BRIGHTNESS_MIN = 8'd0;
    localparam logic [BRIGHT_W-1:0]   RST_BRIGHTNESS_MAX = 8'd15;
    localparam logic [GAIN_W-1:0]     RST_SMOOTHING_GAIN = 16'd41425;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVERAGE,
        S_LAUNCH,
        S_MAP,
        S_SMOOTH,
        S_UPDATE,
        S_FINISH
    } albf_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SQUARE,
        C_SCALE,
        C_COMBINE,
        C_DIVIDE,
        C_DONE
    } curve_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   adc_low;
        logic [ADC_HIGH_W-1:0] adc_high;
        logic [BRIGHT_W-1:0]   bright_min;
        logic [BRIGHT_W-1:0]   bright_max;
    } curve_cfg_t;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] avg;
    } curve_req_t;

    typedef struct packed {
        logic                done;
        logic [BRIGHT_W-1:0] target;
    } curve_rsp_t;

endpackage

// ----- src/ambient_light_brightness_filter.sv -----
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_adc_sample   (12 bit sensor word)
// m_        out        m_valid / m_ready    m_brightness   (8 bit level, only on change)
// cfg_      in         cfg_wr_en            cfg_addr, cfg_wdata (write only)
//
// one word at a time: the next word is taken only once the last one is through,
// and sooner when the window average lands at or beyond a threshold
// the pace is set by the bit-serial units: 12-step average divider, 13+9
// step squaring and scaling, 8-step curve divider, 16-step smoothing multiply
// a result still waiting on m_ready holds the block in its last step only
// reset is synchronous, active low, s_ready stays low while it is held;
// the sample ring has no reset
module ambient_light_brightness_filter import albf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_W-1:0]    s_adc_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [BRIGHT_W-1:0]    m_brightness,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // configuration registers
    curve_cfg_t             cfg_reg;
    logic [GAIN_W-1:0]      gain_reg;

    // window state
    logic [SAMPLE_W-1:0]    window_reg [WINDOW_LEN];
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   win_we;

    // control
    albf_state_t            state_reg, state_next;
    logic [TOP_CNT_W-1:0]   cnt_reg, cnt_next;

    // average divider
    logic [AVG_DEN_W-1:0]   avg_rem_reg, avg_rem_next;
    logic [AVG_DEN_W-1:0]   avg_den_reg, avg_den_next;
    logic [SAMPLE_W-1:0]    avg_q_reg, avg_q_next;

    // smoother
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [DIFF_W-1:0]      diff_reg, diff_next;
    logic [GAIN_W-1:0]      gain_sh_reg, gain_sh_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [BRIGHT_W:0]      old_round_reg, old_round_next;

    // output stage
    logic                   out_valid_reg, out_valid_next;
    logic [BRIGHT_W-1:0]    out_data_reg, out_data_next;

    // datapath helpers
    logic                   window_full;
    logic [SAMPLE_W-1:0]    old_sample;
    logic [COUNT_W-1:0]     count_inc;
    logic [SUM_W-1:0]       sum_acc;
    logic [SLOT_W-1:0]      slot_wrap;
    logic [AVG_NUM_W-1:0]   avg_num;
    logic [AVG_DEN_W:0]     avg_rem_sh;
    logic                   avg_bit;
    logic [AVG_DEN_W-1:0]   avg_rem_step;
    logic [DIFF_W-1:0]      diff_w;
    logic [ACC_W-1:0]       acc_add;
    logic [ACC_W-1:0]       acc_rnd;
    logic [BRIGHT_W:0]      level_round;

    curve_req_t             curve_req;
    curve_rsp_t             curve_rsp;

    albf_curve u_curve (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .req     (curve_req),
        .rsp     (curve_rsp)
    );

    assign s_ready      = aresetn && (state_reg == S_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_brightness = out_data_reg;

    assign curve_req = '{start: (state_reg == S_LAUNCH), avg: avg_q_reg};

    // ring update: drop the oldest sample once the window is full
    assign window_full = (count_reg == COUNT_W'(WINDOW_LEN));
    assign old_sample  = window_reg[slot_reg];
    assign count_inc   = window_full ? count_reg : count_reg + 1'b1;
    assign sum_acc     = (window_full ? sum_reg - SUM_W'(old_sample) : sum_reg)
                       + SUM_W'(s_adc_sample);
    assign slot_wrap   = (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;

    // rounded mean: (2*sum + n) / (2*n)
    assign avg_num      = {sum_acc, 1'b0} + AVG_NUM_W'(count_inc);
    assign avg_rem_sh   = {avg_rem_reg, avg_q_reg[SAMPLE_W-1]};
    assign avg_bit      = avg_rem_sh >= {1'b0, avg_den_reg};
    assign avg_rem_step = avg_bit ? AVG_DEN_W'(avg_rem_sh - {1'b0, avg_den_reg})
                                  : AVG_DEN_W'(avg_rem_sh);

    // smoother: level += round(gain * (target - level)), all mod 2^24
    assign diff_w  = {1'b0, curve_rsp.target, FRAC_W'(0)} - {1'b0, level_reg};
    assign acc_add = gain_sh_reg[GAIN_W-1]
                   ? {{(ACC_W - DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg} : '0;
    assign acc_rnd = acc_reg + ACC_W'(2 ** (FRAC_W - 1));

    // displayed level is the q8.16 level rounded half up
    assign level_round = {1'b0, level_reg[LEVEL_W-1:FRAC_W]}
                       + (BRIGHT_W + 1)'(level_reg[FRAC_W-1]);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        win_we         = 1'b0;
        avg_rem_next   = avg_rem_reg;
        avg_den_next   = avg_den_reg;
        avg_q_next     = avg_q_reg;
        level_next     = level_reg;
        diff_next      = diff_reg;
        gain_sh_next   = gain_sh_reg;
        acc_next       = acc_reg;
        old_round_next = old_round_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    win_we       = 1'b1;
                    count_next   = count_inc;
                    sum_next     = sum_acc;
                    slot_next    = slot_wrap;
                    avg_rem_next = AVG_DEN_W'(avg_num >> SAMPLE_W);
                    avg_q_next   = avg_num[SAMPLE_W-1:0];
                    avg_den_next = {count_inc, 1'b0};
                    cnt_next     = '0;
                    state_next   = S_AVERAGE;
                end
            end
            S_AVERAGE: begin
                // one quotient bit per cycle, msb first
                avg_rem_next = avg_rem_step;
                avg_q_next   = {avg_q_reg[SAMPLE_W-2:0], avg_bit};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == TOP_CNT_W'(SAMPLE_W - 1)) begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                state_next = S_MAP;
            end
            S_MAP: begin
                if (curve_rsp.done) begin
                    diff_next      = diff_w;
                    gain_sh_next   = gain_reg;
                    acc_next       = '0;
                    old_round_next = level_round;
                    cnt_next       = '0;
                    state_next     = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                // signed shift and add over the gain bits
                acc_next     = {acc_reg[ACC_W-2:0], 1'b0} + acc_add;
                gain_sh_next = {gain_sh_reg[GAIN_W-2:0], 1'b0};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == TOP_CNT_W'(GAIN_W - 1)) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // arithmetic shift of the rounded product, kept to level width
                level_next = level_reg + acc_rnd[ACC_W-1:FRAC_W];
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (level_round != old_round_reg) begin
                    // wait here while the output register still holds a word
                    if (!out_valid_reg || m_ready) begin
                        out_valid_next = 1'b1;
                        out_data_next  = level_round[BRIGHT_W-1:0];
                        state_next     = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.adc_low    <= RST_ADC_LOW;
            cfg_reg.adc_high   <= RST_ADC_HIGH;
            cfg_reg.bright_min <= RST_BRIGHTNESS_MIN;
            cfg_reg.bright_max <= RST_BRIGHTNESS_MAX;
            gain_reg           <= RST_SMOOTHING_GAIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ADC_LOW:        cfg_reg.adc_low    <= cfg_wdata[SAMPLE_W-1:0];
                CFG_ADC_HIGH:       cfg_reg.adc_high   <= cfg_wdata[ADC_HIGH_W-1:0];
                CFG_BRIGHTNESS_MIN: cfg_reg.bright_min <= cfg_wdata[BRIGHT_W-1:0];
                CFG_BRIGHTNESS_MAX: cfg_reg.bright_max <= cfg_wdata[BRIGHT_W-1:0];
                CFG_SMOOTHING_GAIN: gain_reg           <= cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sample ring, written on s_valid in the idle state, also while reset is held
    always_ff @(posedge aclk) begin
        if (win_we) begin
            window_reg[slot_reg] <= s_adc_sample;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        avg_rem_reg   <= avg_rem_next;
        avg_den_reg   <= avg_den_next;
        avg_q_reg     <= avg_q_next;
        diff_reg      <= diff_next;
        gain_sh_reg   <= gain_sh_next;
        acc_reg       <= acc_next;
        old_round_reg <= old_round_next;
        out_data_reg  <= out_data_next;
    end

endmodule

// ----- src/albf_curve.sv -----
module albf_curve import albf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  curve_cfg_t cfg,
    input  curve_req_t req,
    output curve_rsp_t rsp
);

    curve_state_t             state_reg, state_next;
    logic [CURVE_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADC_HIGH_W-1:0]    mul_r_reg, mul_r_next;
    logic [ADC_HIGH_W-1:0]    mul_d_reg, mul_d_next;
    logic [ADC_HIGH_W-1:0]    mcand_r_reg, mcand_r_next;
    logic [ADC_HIGH_W-1:0]    mcand_d_reg, mcand_d_next;
    logic [SQ_W-1:0]          sq_r_reg, sq_r_next;
    logic [SQ_W-1:0]          sq_d_reg, sq_d_next;
    logic [PROD_W-1:0]        t_min_reg, t_min_next;
    logic [PROD_W-1:0]        t_span_reg, t_span_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [BRIGHT_W-1:0]      quo_reg, quo_next;

    logic                     at_high, at_low, span_neg, div_bit;
    logic [BRIGHT_W-1:0]      span_mag;
    logic [ADC_HIGH_W-1:0]    range_w, offset_w;
    logic [PROD_W-1:0]        numer;
    logic [DIV_W-1:0]         den;
    logic [DIV_W:0]           rem_sh;

    assign at_high  = {1'b0, req.avg} >= cfg.adc_high;
    assign at_low   = req.avg <= cfg.adc_low;
    assign range_w  = cfg.adc_high - {1'b0, cfg.adc_low};
    assign offset_w = {1'b0, req.avg - cfg.adc_low};
    assign span_neg = cfg.bright_max < cfg.bright_min;
    assign span_mag = span_neg ? cfg.bright_min - cfg.bright_max
                               : cfg.bright_max - cfg.bright_min;

    // span product pulls the numerator up, or down for a falling span but never below r*r
    assign numer  = span_neg ? t_min_reg - t_span_reg : t_min_reg + t_span_reg;
    assign den    = {sq_r_reg, 1'b0};
    assign rem_sh = {rem_reg, quo_reg[BRIGHT_W-1]};
    assign div_bit = rem_sh >= {1'b0, den};

    assign rsp = '{done: (state_reg == C_DONE), target: quo_reg};

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mul_r_next   = mul_r_reg;
        mul_d_next   = mul_d_reg;
        mcand_r_next = mcand_r_reg;
        mcand_d_next = mcand_d_reg;
        sq_r_next    = sq_r_reg;
        sq_d_next    = sq_d_reg;
        t_min_next   = t_min_reg;
        t_span_next  = t_span_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    if (at_high) begin
                        quo_next   = cfg.bright_max;
                        state_next = C_DONE;
                    end else if (at_low) begin
                        quo_next   = cfg.bright_min;
                        state_next = C_DONE;
                    end else begin
                        mcand_r_next = range_w;
                        mul_r_next   = range_w;
                        mcand_d_next = offset_w;
                        mul_d_next   = offset_w;
                        sq_r_next    = '0;
                        sq_d_next    = '0;
                        cnt_next     = '0;
                        state_next   = C_SQUARE;
                    end
                end
            end
            C_SQUARE: begin
                // msb-first shift and add, one multiplier bit per cycle
                sq_r_next = {sq_r_reg[SQ_W-2:0], 1'b0}
                          + (mul_r_reg[ADC_HIGH_W-1] ? SQ_W'(mcand_r_reg) : '0);
                sq_d_next = {sq_d_reg[SQ_W-2:0], 1'b0}
                          + (mul_d_reg[ADC_HIGH_W-1] ? SQ_W'(mcand_d_reg) : '0);
                mul_r_next = {mul_r_reg[ADC_HIGH_W-2:0], 1'b0};
                mul_d_next = {mul_d_reg[ADC_HIGH_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CURVE_CNT_W'(ADC_HIGH_W - 1)) begin
                    mul_r_next  = {cfg.bright_min, 1'b1, (ADC_HIGH_W - BRIGHT_W - 1)'(0)};
                    mul_d_next  = {span_mag, 1'b0, (ADC_HIGH_W - BRIGHT_W - 1)'(0)};
                    t_min_next  = '0;
                    t_span_next = '0;
                    cnt_next    = '0;
                    state_next  = C_SCALE;
                end
            end
            C_SCALE: begin
                t_min_next  = {t_min_reg[PROD_W-2:0], 1'b0}
                            + (mul_r_reg[ADC_HIGH_W-1] ? PROD_W'(sq_r_reg) : '0);
                t_span_next = {t_span_reg[PROD_W-2:0], 1'b0}
                            + (mul_d_reg[ADC_HIGH_W-1] ? PROD_W'(sq_d_reg) : '0);
                mul_r_next  = {mul_r_reg[ADC_HIGH_W-2:0], 1'b0};
                mul_d_next  = {mul_d_reg[ADC_HIGH_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CURVE_CNT_W'(BRIGHT_W)) begin
                    state_next = C_COMBINE;
                end
            end
            C_COMBINE: begin
                rem_next   = numer[PROD_W-1:BRIGHT_W];
                quo_next   = numer[BRIGHT_W-1:0];
                cnt_next   = '0;
                state_next = C_DIVIDE;
            end
            C_DIVIDE: begin
                // restoring division, quotient fits the brightness width
                rem_next = div_bit ? DIV_W'(rem_sh - {1'b0, den}) : DIV_W'(rem_sh);
                quo_next = {quo_reg[BRIGHT_W-2:0], div_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CURVE_CNT_W'(BRIGHT_W - 1)) begin
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_r_reg   <= mul_r_next;
        mul_d_reg   <= mul_d_next;
        mcand_r_reg <= mcand_r_next;
        mcand_d_reg <= mcand_d_next;
        sq_r_reg    <= sq_r_next;
        sq_d_reg    <= sq_d_next;
        t_min_reg   <= t_min_next;
        t_span_reg  <= t_span_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

endmodule

// ----- src/albf_checker.sv -----
module albf_checker import albf_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [BRIGHT_W-1:0] m_brightness
);

    // a pending word is held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_brightness))
        else $error("result word changed or dropped while stalled");

    // an accepted sample keeps the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a sample was taken");

    // a new result only comes out of the busy phase
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while the block was idle");

    // reset leaves the block idle with nothing to send
    a_reset_state: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind ambient_light_brightness_filter albf_checker u_albf_checker (.*);
